// ===== rtl/integer_to_digit_text_defines.svh =====
// Assertion macros used by the integer-to-digit-text controller.
`ifndef INTEGER_TO_DIGIT_TEXT_DEFINES_SVH
`define INTEGER_TO_DIGIT_TEXT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ITDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itdt assertion failed");

// Next-cycle implication, disabled during reset.
`define ITDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itdt assertion failed");

`endif

// ===== rtl/itdt_pkg.sv =====
// Shared types, codes and character constants for the digit text converter.
`timescale 1ns / 1ps
package itdt_pkg;

  // Format selector codes
  localparam logic [1:0] OP_DEC = 2'd0;
  localparam logic [1:0] OP_HEX = 2'd1;
  localparam logic [1:0] OP_TWO = 2'd2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int VALUE_BITS  = 32;
  localparam int CHAR_W      = 7;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 7'h37;  // 'A' - 10
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 7'h22;

  typedef struct packed {
    logic load;         // capture a request
    logic shift;        // one binary-to-BCD step
    logic count;        // latch the significant digit count
    logic emit_prefix;  // push sign or quote
    logic emit_digit;   // push next digit, most significant first
  } cmd_t;

  typedef struct packed {
    logic is_hex;
    logic prefix;       // request needs a leading character
    logic last_digit;   // one digit left
    logic out_free;     // output register can take a character
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_ALPHA + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// ===== rtl/itdt_dp.sv =====
// Datapath: magnitude, shift-add-3 BCD converter, digit count and output register.
`timescale 1ns / 1ps
module itdt_dp #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [itdt_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  itdt_pkg::cmd_t                       cmd,
  output itdt_pkg::status_t                    status,
  input  logic                                 m_tready,
  output logic                                 m_tvalid,
  output logic [itdt_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                 m_tlast
);

  localparam int DEC_DIGITS = (VALUE_WIDTH * 77) / 256 + 2;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int DEPTH      = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DW         = DEPTH * 4;
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int IW         = $clog2(DEPTH);

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   raw_neg;

  logic [1:0]             op;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] bin;
  logic [DW-1:0]          bcd;
  logic [DW-1:0]          bcd_adj;
  logic [CW-1:0]          digit_cnt;
  logic [CW-1:0]          enc;
  logic [CW-1:0]          idx_full;
  logic [IW-1:0]          idx;
  logic [3:0]             cur_digit;
  logic [itdt_pkg::CHAR_W-1:0] char_code;

  // Value field is unsigned-extended or truncated to the working width.
  assign raw     = VALUE_WIDTH'(s_tdata[itdt_pkg::VALUE_BITS+1:2]);
  assign raw_neg = raw[VALUE_WIDTH-1];
  assign mag     = raw_neg ? (~raw + 1'b1) : raw;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  // Highest nonzero digit, at least one digit
  always_comb begin
    enc = CW'(1);
    for (int i = 0; i < DEPTH; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        enc = CW'(i + 1);
      end
    end
  end

  assign idx_full  = digit_cnt - 1'b1;
  assign idx       = idx_full[IW-1:0];
  assign cur_digit = bcd[idx*4 +: 4];
  assign char_code = itdt_pkg::digit_char(cur_digit);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= s_tdata[1:0];
      neg <= raw_neg;
      bin <= mag;
      if (s_tdata[1:0] == itdt_pkg::OP_HEX) begin
        bcd <= DW'(raw);
      end else begin
        bcd <= '0;
      end
    end else if (cmd.shift) begin
      {bcd, bin} <= {bcd_adj[DW-2:0], bin, 1'b0};
    end
    if (cmd.count) begin
      digit_cnt <= (op == itdt_pkg::OP_TWO) ? CW'(2) : enc;
    end else if (cmd.emit_digit) begin
      digit_cnt <= digit_cnt - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_prefix || cmd.emit_digit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_prefix) begin
      m_tdata <= {1'b0, (op == itdt_pkg::OP_HEX) ? itdt_pkg::CH_QUOTE : itdt_pkg::CH_MINUS};
      m_tlast <= 1'b0;
    end else if (cmd.emit_digit) begin
      m_tdata <= {1'b0, char_code};
      m_tlast <= (digit_cnt == CW'(1));
    end
  end

  assign status.is_hex     = (op == itdt_pkg::OP_HEX);
  assign status.prefix     = (op == itdt_pkg::OP_HEX) || (op == itdt_pkg::OP_DEC && neg);
  assign status.last_digit = (digit_cnt == CW'(1));
  assign status.out_free   = !m_tvalid || m_tready;

endmodule

// ===== rtl/itdt_ctrl.sv =====
// Controller: sequences capture, BCD conversion, digit count and character output.
`timescale 1ns / 1ps
`include "integer_to_digit_text_defines.svh"
module itdt_ctrl #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        req_op,
  output itdt_pkg::cmd_t    cmd,
  input  itdt_pkg::status_t status
);

  localparam int BW = $clog2(VALUE_WIDTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CONV   = 3'd1;
  localparam logic [2:0] S_COUNT  = 3'd2;
  localparam logic [2:0] S_PREFIX = 3'd3;
  localparam logic [2:0] S_DIGITS = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [BW-1:0] bit_cnt;
  logic          accept;
  logic          op_valid;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign op_valid = (req_op == itdt_pkg::OP_DEC) || (req_op == itdt_pkg::OP_HEX) ||
                    (req_op == itdt_pkg::OP_TWO);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        // unused selector is dropped with no output
        if (accept && op_valid) begin
          cmd.load   = 1'b1;
          state_next = (req_op == itdt_pkg::OP_HEX) ? S_COUNT : S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        if (bit_cnt == BW'(1)) begin
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.count  = 1'b1;
        state_next = status.prefix ? S_PREFIX : S_DIGITS;
      end
      S_PREFIX: begin
        if (status.out_free) begin
          cmd.emit_prefix = 1'b1;
          state_next      = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.last_digit) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_cnt <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        bit_cnt <= BW'(VALUE_WIDTH);
      end else if (cmd.shift) begin
        bit_cnt <= bit_cnt - 1'b1;
      end
    end
  end

  `ITDT_ASSERT_NOW(a_emit_has_room, cmd.emit_prefix || cmd.emit_digit, status.out_free)
  `ITDT_ASSERT_NOW(a_conv_count_live, state == S_CONV, bit_cnt != '0)
  `ITDT_ASSERT_NEXT(a_last_digit_ends, cmd.emit_digit && status.last_digit, state == S_IDLE)
  `ITDT_ASSERT_NEXT(a_hex_skips_conv, cmd.load && req_op == itdt_pkg::OP_HEX, state == S_COUNT)

endmodule

// ===== rtl/integer_to_digit_text.sv =====
// Top level: signed integer to ASCII decimal, quoted hex or two-digit text.
// Ops 0 and 2: after the request is taken the value is captured, then converted by
//   VALUE_WIDTH shift-add-3 steps, then its digits are counted before the first character.
// Op 1: nibbles need no conversion, so capture is followed directly by the digit count.
// Then one character per cycle while the output is not stalled; a new request is taken
//   the cycle after the last character enters the output register.
// Synchronous active-high reset empties the output register and idles the controller.
`timescale 1ns / 1ps
module integer_to_digit_text #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [itdt_pkg::IN_TDATA_W-1:0]    s_tdata,   // op[1:0], value[33:2], zero pad
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [itdt_pkg::OUT_TDATA_W-1:0]   m_tdata,   // char_code[6:0], zero pad
  output logic                               m_tlast
);

  itdt_pkg::cmd_t    cmd;
  itdt_pkg::status_t status;

  itdt_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .req_op  (s_tdata[1:0]),
    .cmd     (cmd),
    .status  (status)
  );

  itdt_dp #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .status  (status),
    .m_tready(m_tready),
    .m_tvalid(m_tvalid),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the integer to digit text converter.
`timescale 1ns / 1ps
module tb_top;

  localparam int ITEMS_PER_PHASE = 35;
  localparam int ITEMS_LAST      = 30;
  localparam int STALL_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 64;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [itdt_pkg::CHAR_W-1:0] code;
    logic                        last;
  } text_char_t;

  // Holds the characters still owed by the block, oldest first.
  class digit_text_board;
    text_char_t owed_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void owe(input logic [itdt_pkg::CHAR_W-1:0] code, input logic last);
      text_char_t c;
      c.code = code;
      c.last = last;
      owed_chars.push_back(c);
    endfunction

    function logic [itdt_pkg::CHAR_W-1:0] nibble_char(input logic [3:0] d);
      logic [itdt_pkg::CHAR_W-1:0] c;
      if (d < 4'd10) begin
        c = itdt_pkg::CH_ZERO + itdt_pkg::CHAR_W'(d);
      end else begin
        c = itdt_pkg::CH_ALPHA + itdt_pkg::CHAR_W'(d);
      end
      return c;
    endfunction

    // Works out the text of one accepted request.
    function void note_request(input logic [1:0] op,
                               input logic [itdt_pkg::VALUE_BITS-1:0] value);
      logic                            neg;
      logic [itdt_pkg::VALUE_BITS-1:0] mag;
      logic [itdt_pkg::VALUE_BITS-1:0] rest;
      logic [3:0]                      digits [0:9];
      logic [6:0]                      two;
      int                              n;
      neg = value[itdt_pkg::VALUE_BITS-1];
      mag = neg ? (~value + 1'b1) : value;
      n = 0;
      case (op)
        itdt_pkg::OP_DEC: begin
          if (neg) owe(itdt_pkg::CH_MINUS, 1'b0);
          rest = mag;
          do begin
            digits[n] = 4'(rest % 10);
            rest = rest / 10;
            n++;
          end while (rest != 0);
          for (int k = n - 1; k >= 0; k--) owe(nibble_char(digits[k]), k == 0);
        end
        itdt_pkg::OP_HEX: begin
          owe(itdt_pkg::CH_QUOTE, 1'b0);
          rest = value;
          do begin
            digits[n] = rest[3:0];
            rest = rest >> 4;
            n++;
          end while (rest != 0);
          for (int k = n - 1; k >= 0; k--) owe(nibble_char(digits[k]), k == 0);
        end
        itdt_pkg::OP_TWO: begin
          two = 7'(mag % 100);
          owe(itdt_pkg::CH_ZERO + 7'(two / 10), 1'b0);
          owe(itdt_pkg::CH_ZERO + 7'(two % 10), 1'b1);
        end
        default: ;  // unused selector: nothing comes out
      endcase
    endfunction

    task check_char(input logic [itdt_pkg::CHAR_W-1:0] code, input logic last);
      text_char_t want;
      if (owed_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last %0b", code, last));
      end else begin
        want = owed_chars.pop_front();
        if (code !== want.code)
          report_mismatch($sformatf("char 0x%02h, want 0x%02h", code, want.code));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b (char 0x%02h)",
                                    last, want.last, want.code));
      end
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [itdt_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [itdt_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tlast;

  digit_text_board board = new();
  int              send_idle_pct = 10;
  int              recv_idle_pct = 67;
  int              quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  integer_to_digit_text #(.VALUE_WIDTH(itdt_pkg::VALUE_BITS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Output side: check, then pick next cycle's ready.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_char(m_tdata[itdt_pkg::CHAR_W-1:0], m_tlast);
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] op,
                              input logic [itdt_pkg::VALUE_BITS-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= itdt_pkg::IN_TDATA_W'({value, op});
    do @(posedge clk); while (!s_tready);
    board.note_request(op, value);
  endtask

  function automatic logic [itdt_pkg::VALUE_BITS-1:0] pick_value();
    logic [itdt_pkg::VALUE_BITS-1:0] v;
    int                              p;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = $urandom_range(200);
      2: v = 32'h8000_0000 + $urandom_range(3) - ($urandom_range(1) ? 32'd0 : 32'd4);
      3: begin
        p = 1;
        repeat ($urandom_range(9)) p = p * 10;
        v = p - $urandom_range(1);
      end
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(2) == 0) v = ~v + 1'b1;
    return v;
  endfunction

  task automatic random_phase(input int items);
    int            sent;
    logic [1:0]    op;
    sent = 0;
    while (sent < items) begin
      op = ($urandom_range(19) == 0) ? OP_UNUSED : 2'($urandom_range(2));
      send_request(op, pick_value());
      if (op != OP_UNUSED) sent++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, extremes, negative hex, unused selector
    send_request(itdt_pkg::OP_DEC, 32'd0);
    send_request(itdt_pkg::OP_DEC, 32'd1);
    send_request(itdt_pkg::OP_DEC, 32'hFFFF_FFFF);
    send_request(itdt_pkg::OP_DEC, 32'h7FFF_FFFF);
    send_request(itdt_pkg::OP_DEC, 32'h8000_0000);
    send_request(itdt_pkg::OP_DEC, 32'd9);
    send_request(itdt_pkg::OP_DEC, 32'd10);
    send_request(itdt_pkg::OP_DEC, -32'sd1000000000);
    send_request(itdt_pkg::OP_HEX, 32'd0);
    send_request(itdt_pkg::OP_HEX, 32'hFFFF_FFFF);
    send_request(itdt_pkg::OP_HEX, 32'h7FFF_FFFF);
    send_request(itdt_pkg::OP_HEX, 32'h8000_0000);
    send_request(itdt_pkg::OP_HEX, 32'h0ABC_DEF0);
    send_request(itdt_pkg::OP_HEX, 32'd15);
    send_request(itdt_pkg::OP_HEX, 32'd16);
    send_request(itdt_pkg::OP_TWO, 32'd0);
    send_request(itdt_pkg::OP_TWO, 32'd99);
    send_request(itdt_pkg::OP_TWO, 32'd100);
    send_request(itdt_pkg::OP_TWO, 32'h8000_0000);
    send_request(itdt_pkg::OP_TWO, 32'h7FFF_FFFF);
    send_request(itdt_pkg::OP_TWO, -32'sd7);
    send_request(OP_UNUSED, 32'h1234_5678);
    send_request(OP_UNUSED, 32'hFFFF_FFFF);
    send_request(itdt_pkg::OP_DEC, 32'd5);

    random_phase(ITEMS_PER_PHASE);
    send_idle_pct = 67;
    recv_idle_pct = 10;
    random_phase(ITEMS_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(ITEMS_LAST);
    s_tvalid <= 1'b0;

    while (board.owed_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/itdt_pkg.sv
rtl/itdt_dp.sv
rtl/itdt_ctrl.sv
rtl/integer_to_digit_text.sv
tb/tb_top.sv
